// ===== src/line_rasterizer_assert.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a property holds on every clock edge outside reset.
`define LR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("line rasterizer assertion failed");

// Checks that a condition never occurs outside reset.
`define LR_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("line rasterizer forbidden condition seen");

`else

`define LR_ASSERT(label, clk, rst, prop)
`define LR_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== src/lr_pkg.sv =====
package lr_pkg;

  // Coordinate and error widths; the error term carries sign and headroom.
  localparam int COORD_BITS = 8;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 16;

  // Configuration port geometry.
  localparam int DATA_BITS    = 32;
  localparam int REG_IDX_BITS = 2;
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // Request operation codes.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_BITS-1:0] REG_KEY_SKIP_ENABLE = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_KEY_COLOR       = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_OR_MODE         = 2'd2;

  typedef struct packed {
    logic   operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t line_color_in;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   merge_or;
    logic   last_pixel;
  } pixel_t;

  typedef struct packed {
    logic   key_skip_enable;
    color_t key_color;
    logic   or_mode;
  } cfg_t;

  // Moves a coordinate one step, wrapping at the coordinate width.
  function automatic coord_t step_coord(coord_t c, logic neg);
    return neg ? coord_t'(c - coord_t'(1)) : coord_t'(c + coord_t'(1));
  endfunction

endpackage

// ===== src/lr_regs.sv =====
module lr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lr_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lr_pkg::DATA_BITS-1:0]  prdata,
  output logic                          pready,
  output lr_pkg::cfg_t                  cfg
);
  import lr_pkg::*;

  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  // Register writes in the access phase; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_SKIP_ENABLE: cfg.key_skip_enable <= pwdata[0];
        REG_KEY_COLOR:       cfg.key_color       <= pwdata[COLOR_BITS-1:0];
        REG_OR_MODE:         cfg.or_mode         <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_KEY_SKIP_ENABLE: prdata = {{(DATA_BITS-1){1'b0}}, cfg.key_skip_enable};
      REG_KEY_COLOR:       prdata = {{(DATA_BITS-COLOR_BITS){1'b0}}, cfg.key_color};
      REG_OR_MODE:         prdata = {{(DATA_BITS-1){1'b0}}, cfg.or_mode};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== src/line_rasterizer.sv =====
// Bresenham line generator for all eight octants. A start request loads two
// endpoints and a color and yields no pixel; each advance request then yields
// one pixel, the final one marked last_pixel, after which advances yield
// nothing until the next start; a start whose color equals the enabled key
// color starts no line. The block takes one request per clock unless stalled
// and delivers at most one pixel per clock, through the request register and
// then the pixel register. The rate is set by the per-pixel error update, an
// add/compare/step loop on the line state. The pixel register decouples the
// sides: requests keep flowing while a pixel waits, and outside reset only an
// advance that meets a stalled, full pixel register holds the request side.
// Configuration is an APB register port; no clearing pass follows reset.
`include "line_rasterizer_assert.svh"

module line_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  lr_pkg::cmd_t                  cmd,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output lr_pkg::pixel_t                pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lr_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lr_pkg::DATA_BITS-1:0]  prdata,
  output logic                          pready
);
  import lr_pkg::*;

  cfg_t cfg;

  // Request register.
  logic   req_valid;
  cmd_t   req;

  // Line state.
  coord_t cur_x;
  coord_t cur_y;
  coord_t major_end;
  err_t   err_term;
  coord_t delta_x_abs;
  coord_t delta_y_abs;
  logic   x_step_neg;
  logic   y_step_neg;
  logic   major_is_x;
  logic   line_active;
  color_t held_color;

  // Combinational work on the registered request.
  logic   is_start;
  logic   produces;
  logic   consume;
  logic   cmd_accept;
  logic   s_x_neg;
  logic   s_y_neg;
  coord_t s_dx;
  coord_t s_dy;
  logic   s_major_x;
  coord_t s_dmaj;
  coord_t s_dmin;
  err_t   s_err;
  logic   s_key_hit;
  coord_t a_major;
  logic   a_last;
  coord_t a_dmaj;
  coord_t a_dmin;
  logic   a_err_pos;
  err_t   a_err_mid;
  err_t   a_err_next;

  lr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the request register moves on unless its pixel is blocked.
  assign is_start   = (req.operation == OP_START);
  assign produces   = req_valid && !is_start && line_active;
  assign consume    = req_valid && (!produces || !pixel_valid || !pixel_stall);
  assign cmd_stall  = rst || (req_valid && !consume);
  assign cmd_accept = cmd_valid && !cmd_stall;

  // Start: directions, absolute deltas, major axis and initial error.
  always_comb begin
    s_x_neg   = req.x_end < req.x_start;
    s_y_neg   = req.y_end < req.y_start;
    s_dx      = s_x_neg ? coord_t'(req.x_start - req.x_end)
                        : coord_t'(req.x_end - req.x_start);
    s_dy      = s_y_neg ? coord_t'(req.y_start - req.y_end)
                        : coord_t'(req.y_end - req.y_start);
    s_major_x = s_dx >= s_dy;
    s_dmaj    = s_major_x ? s_dx : s_dy;
    s_dmin    = s_major_x ? s_dy : s_dx;
    s_err     = err_t'({{(ERR_BITS-COORD_BITS){1'b0}}, s_dmin}
              - {{(ERR_BITS-COORD_BITS+1){1'b0}}, s_dmaj[COORD_BITS-1:1]});
    s_key_hit = cfg.key_skip_enable && (req.line_color_in == cfg.key_color);
  end

  // Advance: end test and error update.
  always_comb begin
    a_major    = major_is_x ? cur_x : cur_y;
    a_last     = (a_major == major_end);
    a_dmaj     = major_is_x ? delta_x_abs : delta_y_abs;
    a_dmin     = major_is_x ? delta_y_abs : delta_x_abs;
    a_err_pos  = !err_term[ERR_BITS-1] && (err_term != '0);
    a_err_mid  = a_err_pos
               ? err_t'(err_term - {{(ERR_BITS-COORD_BITS){1'b0}}, a_dmaj})
               : err_term;
    a_err_next = err_t'(a_err_mid + {{(ERR_BITS-COORD_BITS){1'b0}}, a_dmin});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      pixel_valid <= 1'b0;
      line_active <= 1'b0;
    end else begin
      if (cmd_accept) begin
        req_valid <= 1'b1;
      end else if (consume) begin
        req_valid <= 1'b0;
      end
      if (consume && produces) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      if (consume && is_start) begin
        line_active <= !s_key_hit;
      end else if (consume && produces && a_last) begin
        line_active <= 1'b0;
      end
    end
  end

  // Request payload register.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      req <= cmd;
    end
  end

  // Line state and pixel payload.
  always_ff @(posedge clk) begin
    if (consume && is_start) begin
      cur_x       <= req.x_start;
      cur_y       <= req.y_start;
      x_step_neg  <= s_x_neg;
      y_step_neg  <= s_y_neg;
      delta_x_abs <= s_dx;
      delta_y_abs <= s_dy;
      major_is_x  <= s_major_x;
      major_end   <= s_major_x ? req.x_end : req.y_end;
      err_term    <= s_err;
      held_color  <= req.line_color_in;
    end else if (consume && produces) begin
      pixel.pixel_x     <= cur_x;
      pixel.pixel_y     <= cur_y;
      pixel.pixel_color <= held_color;
      pixel.merge_or    <= cfg.or_mode;
      pixel.last_pixel  <= a_last;
      if (!a_last) begin
        if (major_is_x) begin
          cur_x <= step_coord(cur_x, x_step_neg);
          if (a_err_pos) begin
            cur_y <= step_coord(cur_y, y_step_neg);
          end
        end else begin
          cur_y <= step_coord(cur_y, y_step_neg);
          if (a_err_pos) begin
            cur_x <= step_coord(cur_x, x_step_neg);
          end
        end
        err_term <= a_err_next;
      end
    end
  end

  // The pixel register is never overwritten while a stalled pixel waits.
  `LR_ASSERT_NEVER(a_no_pixel_overwrite, clk, rst, pixel_valid && pixel_stall && consume && produces)
  // The request side stalls only while an item is held in the request register.
  `LR_ASSERT(a_stall_has_item, clk, rst, cmd_stall |-> req_valid)
  // Emitting the last pixel ends the line.
  `LR_ASSERT(a_last_ends_line, clk, rst, (consume && produces && a_last) |=> !line_active)
  // A keyed start leaves no line active.
  `LR_ASSERT(a_key_skip, clk, rst, (consume && is_start && s_key_hit) |=> !line_active)
  // A pixel is only loaded from an active line.
  `LR_ASSERT(a_pixel_from_line, clk, rst, $rose(pixel_valid) |-> $past(line_active))

endmodule
